FILE: design/sorted_priority_queue_unit_defines.svh
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_defines
// Assertion macros shared by the priority queue modules.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// clocked check, off while reset is held
`define SPQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("spq assertion failed");

// clocked check that also runs through reset
`define SPQ_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("spq assertion failed");

`else

`define SPQ_ASSERT(label, clk, rst_n, prop)
`define SPQ_ASSERT_NR(label, clk, prop)

`endif

`endif

FILE: design/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Codes, field widths and controller/datapath link types of the queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int PRIO_W   = 16;
    localparam int TAG_W    = 16;
    localparam int COUNT_W  = 5;

    // operation codes
    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the accepted item
        logic exec;   // carry out the captured operation
    } spq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_busy;   // result register holds a result not yet taken
    } spq_stat_t;

endpackage

FILE: design/sorted_priority_queue_unit.sv
// Sorted priority queue of DEPTH entries, each a signed Q8.8 priority and a
// 16-bit tag, held in shift cells in descending order. Each accepted item is
// one operation (enqueue, dequeue, peek or clear) and yields exactly one
// result: status, the tail entry for dequeue and peek (the smallest priority,
// newest among equals), and the entry count after the operation. Each item is
// first captured, then executed: all cells compare against the new priority
// in parallel and shift or load. No new item is accepted until the captured
// one has executed. The result register holds a result until it is taken,
// and the execute cycle waits while it is still occupied.
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Top level: controller and slot datapath.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [spq_pkg::OP_W-1:0]             s_op,
    input  logic signed [spq_pkg::PRIO_W-1:0]    s_in_priority,
    input  logic [spq_pkg::TAG_W-1:0]            s_in_tag,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [spq_pkg::STATUS_W-1:0]         m_status,
    output logic signed [spq_pkg::PRIO_W-1:0]    m_out_priority,
    output logic [spq_pkg::TAG_W-1:0]            m_out_tag,
    output logic [spq_pkg::COUNT_W-1:0]          m_entry_count
);
    import spq_pkg::*;

    spq_cmd_t  cmd;
    spq_stat_t stat;

    // sequencer
    spq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // slot cells and result register
    spq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_op           (s_op),
        .s_in_priority  (s_in_priority),
        .s_in_tag       (s_in_tag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_priority (m_out_priority),
        .m_out_tag      (m_out_tag),
        .m_entry_count  (m_entry_count)
    );

endmodule

FILE: design/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: captures one item, then executes it once the result register
// is free.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_unit_defines.svh"

module spq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  spq_pkg::spq_stat_t stat,
    output spq_pkg::spq_cmd_t  cmd
);
    import spq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    // handshake and commands
    assign s_ready  = (state_reg == ST_IDLE);
    assign cmd.load = s_valid && s_ready;
    assign cmd.exec = (state_reg == ST_EXEC) && !stat.out_busy;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd.exec) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SPQ_ASSERT_NR(a_reset_to_idle, aclk, !aresetn |=> state_reg == ST_IDLE)
    `SPQ_ASSERT(a_load_starts_exec, aclk, aresetn, cmd.load |=> state_reg == ST_EXEC)
    `SPQ_ASSERT(a_no_exec_when_busy, aclk, aresetn, stat.out_busy |-> !cmd.exec)

endmodule

FILE: design/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath
// Sorted slot cells with parallel insert compare, fill count and the
// result register.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_unit_defines.svh"

module spq_datapath #(
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  spq_pkg::spq_cmd_t                    cmd,
    output spq_pkg::spq_stat_t                   stat,
    input  logic [spq_pkg::OP_W-1:0]             s_op,
    input  logic signed [spq_pkg::PRIO_W-1:0]    s_in_priority,
    input  logic [spq_pkg::TAG_W-1:0]            s_in_tag,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [spq_pkg::STATUS_W-1:0]         m_status,
    output logic signed [spq_pkg::PRIO_W-1:0]    m_out_priority,
    output logic [spq_pkg::TAG_W-1:0]            m_out_tag,
    output logic [spq_pkg::COUNT_W-1:0]          m_entry_count
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    // captured item
    logic [OP_W-1:0]          op_reg;
    logic signed [PRIO_W-1:0] prio_reg;
    logic [TAG_W-1:0]         tag_reg;

    // slot cells, descending priority from slot 0
    logic signed [PRIO_W-1:0] slot_prio_reg [DEPTH];
    logic [TAG_W-1:0]         slot_tag_reg  [DEPTH];
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;

    // result register
    logic                     m_valid_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic signed [PRIO_W-1:0] res_prio_reg;
    logic signed [PRIO_W-1:0] res_prio_next;
    logic [TAG_W-1:0]         res_tag_reg;
    logic [TAG_W-1:0]         res_tag_next;
    logic [CNT_W-1:0]         res_count_reg;

    logic             full;
    logic             empty;
    logic [CNT_W-1:0] tail_pos;
    logic [IDX_W-1:0] tail_idx;
    logic             do_insert;
    logic [DEPTH-1:0] past_new;   // new entry belongs at or before this slot
    logic [DEPTH-1:0] ins_here;
    logic [DEPTH-1:0] shift_in;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign tail_pos = count_reg - 1'b1;
    assign tail_idx = tail_pos[IDX_W-1:0];
    assign do_insert = cmd.exec && (op_reg == OP_ENQUEUE) && !full;

    // capture the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_op;
            prio_reg <= s_in_priority;
            tag_reg  <= s_in_tag;
        end
    end

    // parallel compare: first slot whose priority is strictly smaller, or the end
    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            past_new[k] = ((CNT_W'(k) < count_reg) && (prio_reg > slot_prio_reg[k]))
                          || (CNT_W'(k) == count_reg);
        end
        for (int k = 0; k < DEPTH; k++) begin
            if (k == 0) begin
                ins_here[k] = past_new[k];
                shift_in[k] = 1'b0;
            end else begin
                ins_here[k] = past_new[k] && !past_new[k-1]
                              && (CNT_W'(k) <= count_reg);
                shift_in[k] = past_new[k-1] && (CNT_W'(k) <= count_reg);
            end
        end
    end

    // slot cells: take the new entry or the left neighbor
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            always_ff @(posedge aclk) begin
                if (do_insert && ins_here[g]) begin
                    slot_prio_reg[g] <= prio_reg;
                    slot_tag_reg[g]  <= tag_reg;
                end
            end
        end else begin : g_body
            always_ff @(posedge aclk) begin
                if (do_insert && ins_here[g]) begin
                    slot_prio_reg[g] <= prio_reg;
                    slot_tag_reg[g]  <= tag_reg;
                end else if (do_insert && shift_in[g]) begin
                    slot_prio_reg[g] <= slot_prio_reg[g-1];
                    slot_tag_reg[g]  <= slot_tag_reg[g-1];
                end
            end
        end
    end

    // operation result and new fill count
    always_comb begin
        count_next    = count_reg;
        status_next   = ST_OK;
        res_prio_next = '0;
        res_tag_next  = '0;
        case (op_reg)
            OP_ENQUEUE: begin
                if (full) begin
                    status_next = ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            OP_DEQUEUE, OP_PEEK: begin
                if (empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    res_prio_next = slot_prio_reg[tail_idx];
                    res_tag_next  = slot_tag_reg[tail_idx];
                    if (op_reg == OP_DEQUEUE) begin
                        count_next = tail_pos;
                    end
                end
            end
            OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    // fill count and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.exec) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg    <= status_next;
            res_prio_reg  <= res_prio_next;
            res_tag_reg   <= res_tag_next;
            res_count_reg <= count_next;
        end
    end

    assign stat.out_busy  = m_valid_reg && !m_ready;
    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_out_priority = res_prio_reg;
    assign m_out_tag      = res_tag_reg;
    assign m_entry_count  = COUNT_W'(res_count_reg);

    `SPQ_ASSERT(a_count_in_range, aclk, aresetn, count_reg <= CNT_W'(DEPTH))
    `SPQ_ASSERT(a_exec_needs_free_out, aclk, aresetn, cmd.exec |-> !(m_valid_reg && !m_ready))
    `SPQ_ASSERT(a_dequeue_drops_one, aclk, aresetn, (cmd.exec && op_reg == OP_DEQUEUE && !empty) |=> count_reg == $past(tail_pos))
    `SPQ_ASSERT(a_full_drop_keeps_count, aclk, aresetn, (cmd.exec && op_reg == OP_ENQUEUE && full) |=> (count_reg == $past(count_reg)) && (m_status == ST_FULL))

endmodule

FILE: tb/spq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker
// Watches both channels of the sorted priority queue, keeps its own ordered
// copy of the entries, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module spq_checker #(
    parameter int DEPTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic [spq_pkg::OP_W-1:0]             s_op,
    input  logic signed [spq_pkg::PRIO_W-1:0]    s_in_priority,
    input  logic [spq_pkg::TAG_W-1:0]            s_in_tag,
    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [spq_pkg::STATUS_W-1:0]         m_status,
    input  logic signed [spq_pkg::PRIO_W-1:0]    m_out_priority,
    input  logic [spq_pkg::TAG_W-1:0]            m_out_tag,
    input  logic [spq_pkg::COUNT_W-1:0]          m_entry_count,
    output int                                   fail_count,
    output int                                   pending_results
);
    import spq_pkg::*;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } queue_entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PRIO_W-1:0]   prio;
        logic [TAG_W-1:0]    tag;
        logic [COUNT_W-1:0]  count;
    } queue_result_t;

    // shadow of the queue: index 0 largest priority, tail smallest
    queue_entry_t  ordered_entries [DEPTH];
    int            held_count;
    queue_result_t awaited_results [$];

    task automatic report_mismatch(input string detail);
        $display("mismatch at %0t: %s", $time, detail);
        fail_count++;
    endtask

    // apply one operation to the shadow queue and return its result
    function automatic queue_result_t predict_outcome(
        input logic [OP_W-1:0]          op,
        input logic signed [PRIO_W-1:0] prio,
        input logic [TAG_W-1:0]         tag
    );
        queue_result_t res;
        int            slot_at;
        res = '0;
        case (op)
            OP_ENQUEUE: begin
                if (held_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // goes before the first strictly smaller priority
                    slot_at = held_count;
                    for (int k = 0; k < held_count; k++) begin
                        if (prio > $signed(ordered_entries[k].prio)) begin
                            slot_at = k;
                            break;
                        end
                    end
                    for (int k = held_count; k > slot_at; k--) begin
                        ordered_entries[k] = ordered_entries[k-1];
                    end
                    ordered_entries[slot_at] = '{prio: prio, tag: tag};
                    held_count++;
                    res.status = ST_OK;
                end
            end
            OP_DEQUEUE, OP_PEEK: begin
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.status = ST_OK;
                    res.prio   = ordered_entries[held_count-1].prio;
                    res.tag    = ordered_entries[held_count-1].tag;
                    if (op == OP_DEQUEUE) begin
                        held_count--;
                    end
                end
            end
            default: begin
                held_count = 0;
                res.status = ST_OK;
            end
        endcase
        res.count = COUNT_W'(held_count);
        return res;
    endfunction

    initial begin
        fail_count      = 0;
        pending_results = 0;
        held_count      = 0;
    end

    // results are checked before the same edge's request is predicted
    always @(posedge aclk) begin
        queue_result_t want;
        if (!aresetn) begin
            held_count = 0;
            awaited_results.delete();
            for (int k = 0; k < DEPTH; k++) begin
                ordered_entries[k] = '0;
            end
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    want = awaited_results.pop_front();
                    if (m_status !== want.status)
                        report_mismatch($sformatf("m_status got %0d expected %0d",
                                                  m_status, want.status));
                    if (m_out_priority !== want.prio)
                        report_mismatch($sformatf("m_out_priority got %0d expected %0d",
                                                  m_out_priority, $signed(want.prio)));
                    if (m_out_tag !== want.tag)
                        report_mismatch($sformatf("m_out_tag got %h expected %h",
                                                  m_out_tag, want.tag));
                    if (m_entry_count !== want.count)
                        report_mismatch($sformatf("m_entry_count got %0d expected %0d",
                                                  m_entry_count, want.count));
                end
            end
            if (s_valid && s_ready) begin
                awaited_results.push_back(predict_outcome(s_op, s_in_priority, s_in_tag));
            end
        end
        pending_results = awaited_results.size();
    end

endmodule

FILE: tb/sorted_priority_queue_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit_tb
// Drives enqueue, dequeue, peek and clear transfers into the priority queue,
// first a directed run through empty, tie and full cases, then biased random
// phases that fill, drain and mix, with random idling on both sides and
// long receiver hold-offs. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_tb;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1020;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [OP_W-1:0]          s_op;
    logic signed [PRIO_W-1:0] s_in_priority;
    logic [TAG_W-1:0]         s_in_tag;
    logic                     m_valid;
    logic                     m_ready;
    logic [STATUS_W-1:0]      m_status;
    logic signed [PRIO_W-1:0] m_out_priority;
    logic [TAG_W-1:0]         m_out_tag;
    logic [COUNT_W-1:0]       m_entry_count;

    int   fail_count;
    int   pending_results;
    bit   hold_request;
    bit   no_idle;

    sorted_priority_queue_unit #(
        .DEPTH(QUEUE_DEPTH)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_in_priority (s_in_priority),
        .s_in_tag      (s_in_tag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_priority(m_out_priority),
        .m_out_tag     (m_out_tag),
        .m_entry_count (m_entry_count)
    );

    spq_checker #(
        .DEPTH(QUEUE_DEPTH)
    ) checker_inst (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_in_priority  (s_in_priority),
        .s_in_tag       (s_in_tag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_out_priority (m_out_priority),
        .m_out_tag      (m_out_tag),
        .m_entry_count  (m_entry_count),
        .fail_count     (fail_count),
        .pending_results(pending_results)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // offer one request and hold it until the transfer happens
    task automatic send_request(input logic [OP_W-1:0] op,
                                input logic signed [PRIO_W-1:0] prio,
                                input logic [TAG_W-1:0] tag);
        s_valid       <= 1'b1;
        s_op          <= op;
        s_in_priority <= prio;
        s_in_tag      <= tag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic idle_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // mostly full-range values, some crowded near zero for ties, some extremes
    function automatic logic signed [PRIO_W-1:0] pick_priority();
        int style;
        style = $urandom_range(0, 9);
        if (style < 5) return PRIO_W'($urandom);
        if (style < 8) return PRIO_W'($urandom_range(0, 6) - 3);
        case ($urandom_range(0, 3))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0001;
            default: return 16'shFFFF;
        endcase
    endfunction

    // receiver: random stall bursts, one long hold-off on request, none at the end
    initial begin
        int stall_left;
        int long_left;
        stall_left = 0;
        long_left  = 0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            if (long_left > 0) begin
                m_ready <= 1'b0;
                long_left--;
            end else if (hold_request) begin
                hold_request = 1'b0;
                long_left    = 79;
                m_ready <= 1'b0;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if ($urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial begin
        int               mode;
        int               pick;
        bit               gaps_on;
        logic [OP_W-1:0]  op;

        s_valid       = 1'b0;
        s_op          = OP_ENQUEUE;
        s_in_priority = '0;
        s_in_tag      = '0;
        aresetn       = 1'b0;
        hold_request  = 1'b0;
        no_idle       = 1'b0;
        mode          = 0;
        gaps_on       = 1'b1;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty errors, extremes and a tie between equal priorities
        send_request(OP_DEQUEUE, 16'sh0000, 16'h0000);
        send_request(OP_PEEK,    16'sh0000, 16'h0000);
        send_request(OP_ENQUEUE, 16'sh7FFF, 16'hFFFF);
        send_request(OP_ENQUEUE, 16'sh8000, 16'h0000);
        send_request(OP_ENQUEUE, 16'shFFFF, 16'hA5A5);
        send_request(OP_ENQUEUE, 16'shFFFF, 16'h5A5A);
        send_request(OP_PEEK,    16'sh0000, 16'h0000);
        send_request(OP_DEQUEUE, 16'sh0000, 16'h0000);
        send_request(OP_DEQUEUE, 16'sh0000, 16'h0000);
        send_request(OP_DEQUEUE, 16'sh0000, 16'h0000);

        // fill to the brim, then one more to hit the full drop
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            send_request(OP_ENQUEUE, pick_priority(), TAG_W'($urandom));
        end
        send_request(OP_ENQUEUE, 16'sh1234, 16'hBEEF);
        send_request(OP_PEEK,    16'sh0000, 16'h0000);
        send_request(OP_CLEAR,   16'sh0000, 16'h0000);
        send_request(OP_DEQUEUE, 16'sh0000, 16'h0000);

        // random phases: fill-heavy, drain-heavy and mixed
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 32 == 0) begin
                mode    = $urandom_range(0, 2);
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            if (n == 300 || n == 650) hold_request = 1'b1;
            if (n == RANDOM_ITEMS - 150) no_idle = 1'b1;

            pick = $urandom_range(0, 99);
            case (mode)
                0: op = (pick < 80) ? OP_ENQUEUE : (pick < 92) ? OP_DEQUEUE :
                        (pick < 99) ? OP_PEEK : OP_CLEAR;
                1: op = (pick < 20) ? OP_ENQUEUE : (pick < 80) ? OP_DEQUEUE :
                        (pick < 99) ? OP_PEEK : OP_CLEAR;
                default: op = (pick < 45) ? OP_ENQUEUE : (pick < 80) ? OP_DEQUEUE :
                              (pick < 95) ? OP_PEEK : OP_CLEAR;
            endcase

            if (!no_idle && gaps_on && $urandom_range(0, 5) == 0) begin
                idle_sender($urandom_range(1, 9));
            end
            send_request(op, pick_priority(), TAG_W'($urandom));
        end

        // drain
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
